### rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the text console character writer.
// Depends on nothing; tcw_front, tcw_fifo, tcw_back and the core import it.
package tcw_pkg;

   // Character codes that the command decoder recognizes.
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_BELL  = 8'h07;
   localparam logic [7:0] CHAR_BS    = 8'h08;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_NL    = 8'h0A;
   localparam logic [7:0] CHAR_FF    = 8'h0C;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Attribute written into every cell by the clearing pass after reset.
   localparam logic [7:0] ATTR_RESET = 8'd15;

   // A tab expands to this many blank puts.
   localparam int unsigned TAB_WIDTH = 4;

   // Command queue between the front and the back.
   localparam int unsigned FIFO_DEPTH = 2;

   // Payload field widths.
   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned ATTR_W   = 8;
   localparam int unsigned COL_W    = 7;
   localparam int unsigned ROW_W    = 5;
   localparam int unsigned LINEAR_W = 11;

   // Operation codes of the request channel.
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // Classified commands handed from the front to the back.
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_PUT,
      CMD_TAB,
      CMD_NEWLINE,
      CMD_CR,
      CMD_BS,
      CMD_FF,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic             in_range;
      logic [CHAR_W-1:0] char_byte;
      logic [COL_W-1:0] read_column;
      logic [ROW_W-1:0] read_row;
   } cmd_type;

   // States of the back-end sequencer.
   typedef enum logic [2:0] {
      ST_INIT_CLEAR,
      ST_IDLE,
      ST_READ_WAIT,
      ST_PUT,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK,
      ST_CLEAR,
      ST_DONE
   } st_type;

endpackage

### rtl/tcw_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the text console character writer: request, response
// and attribute register write. Depends on nothing.

interface tcw_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] char_byte;
   logic [6:0] read_column;
   logic [4:0] read_row;

   modport source (output valid, operation, char_byte, read_column, read_row,
                   input ready);
   modport sink   (input valid, operation, char_byte, read_column, read_row,
                   output ready);
endinterface

interface tcw_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  cursor_column;
   logic [4:0]  cursor_row;
   logic [10:0] cursor_linear;
   logic [7:0]  cell_char;
   logic [7:0]  cell_attr;
   logic        scrolled;

   modport source (output valid, cursor_column, cursor_row, cursor_linear,
                   cell_char, cell_attr, scrolled, input ready);
   modport sink   (input valid, cursor_column, cursor_row, cursor_linear,
                   cell_char, cell_attr, scrolled, output ready);
endinterface

interface tcw_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### rtl/tcw_front.sv
`timescale 1ns / 1ps
// Front end: takes request transfers and classifies them into commands.
// Depends on tcw_pkg and tcw_req_if.
module tcw_front #(
   parameter int unsigned COLUMNS = 80,
   parameter int unsigned ROWS    = 25
) (
   tcw_req_if.sink           req_ch,
   input  logic              queue_full,
   output logic              push,
   output tcw_pkg::cmd_type  cmd
);
   import tcw_pkg::*;

   // Accept whenever the queue has room.
   assign req_ch.ready = !queue_full;
   assign push         = req_ch.valid && !queue_full;

   // Decode the operation and the control codes.
   always_comb begin
      cmd.char_byte   = req_ch.char_byte;
      cmd.read_column = req_ch.read_column;
      cmd.read_row    = req_ch.read_row;
      cmd.in_range    = (32'(req_ch.read_column) < COLUMNS) &&
                        (32'(req_ch.read_row) < ROWS);
      cmd.kind        = CMD_PUT;
      if (req_ch.operation == OP_READ) begin
         cmd.kind = CMD_READ;
      end else begin
         case (req_ch.char_byte)
            CHAR_NUL, CHAR_BELL: cmd.kind = CMD_NOP;
            CHAR_NL:             cmd.kind = CMD_NEWLINE;
            CHAR_CR:             cmd.kind = CMD_CR;
            CHAR_TAB:            cmd.kind = CMD_TAB;
            CHAR_BS:             cmd.kind = CMD_BS;
            CHAR_FF:             cmd.kind = CMD_FF;
            default:             cmd.kind = CMD_PUT;
         endcase
      end
   end

endmodule

### rtl/tcw_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back end.
// Depends on tcw_pkg.
module tcw_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tcw_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output tcw_pkg::cmd_type  head_cmd,
   output logic              not_empty,
   output logic              full
);
   import tcw_pkg::*;

   localparam int unsigned IW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int unsigned NW = $clog2(FIFO_DEPTH + 1);

   cmd_type         entry_ff [FIFO_DEPTH];
   logic [IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]   count_ff, count_in;

   assign head_cmd  = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == NW'(FIFO_DEPTH));

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage for queued commands.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push || pop)
      else $error("command pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("command popped from an empty queue");

endmodule

### rtl/tcw_back.sv
`timescale 1ns / 1ps
// Back end: screen store, cursor, attribute register, scroll and clear
// sequencer and the response register. Depends on tcw_pkg and the interfaces.
module tcw_back #(
   parameter int unsigned COLUMNS       = 80,
   parameter int unsigned ROWS          = 25,
   parameter int unsigned RESERVED_ROWS = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  tcw_pkg::cmd_type  cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   tcw_csr_if.sink           csr_ch,
   tcw_rsp_if.source         rsp_ch
);
   import tcw_pkg::*;

   localparam int unsigned CELLS = COLUMNS * ROWS;
   localparam int unsigned CW    = $clog2(COLUMNS);
   localparam int unsigned RW    = $clog2(ROWS);
   localparam int unsigned AW    = $clog2(CELLS);
   localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
   localparam logic [RW-1:0] ROW_HOME  = RW'(RESERVED_ROWS);
   localparam logic [AW-1:0] CELL_LAST = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_SRC0 = AW'((RESERVED_ROWS + 1) * COLUMNS);
   localparam logic [AW-1:0] BOT_ROW0  = AW'((ROWS - 1) * COLUMNS);
   localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
   localparam bit            HAS_COPY  = (RESERVED_ROWS + 1 < ROWS);
   localparam int unsigned   PW        = $clog2(TAB_WIDTH + 1);

   st_type               state_ff, state_in;
   logic [CW-1:0]        col_ff, col_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [ATTR_W-1:0]    attr_ff, attr_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic                 iss_ff, iss_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [AW-1:0]        wr_addr_ff, wr_addr_in;
   logic [PW-1:0]        puts_ff, puts_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 scr_ff, scr_in;
   logic [15:0]          rd_data_ff;
   logic [15:0]          mem [CELLS];

   logic                 out_valid_ff, out_valid_in;
   logic [COL_W-1:0]     out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic [LINEAR_W-1:0]  out_lin_ff, out_lin_in;
   logic [CHAR_W-1:0]    out_char_ff, out_char_in;
   logic [ATTR_W-1:0]    out_attr_ff, out_attr_in;
   logic                 out_scr_ff, out_scr_in;

   logic                 mem_we, mem_re;
   logic [AW-1:0]        mem_waddr, mem_raddr;
   logic [15:0]          mem_wdata;
   logic [AW-1:0]        cur_addr;
   logic [AW-1:0]        read_addr;
   logic                 out_free;
   logic [PW-1:0]        puts_left;

   assign cur_addr  = AW'(row_ff) * ROW_STEP + AW'(col_ff);
   assign read_addr = AW'(cmd.read_row) * ROW_STEP + AW'(cmd.read_column);
   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign puts_left = puts_ff - 1'b1;

   assign csr_ch.ready = 1'b1;

   // Response register drives the result channel.
   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.cursor_column = out_col_ff;
   assign rsp_ch.cursor_row    = out_row_ff;
   assign rsp_ch.cursor_linear = out_lin_ff;
   assign rsp_ch.cell_char     = out_char_ff;
   assign rsp_ch.cell_attr     = out_attr_ff;
   assign rsp_ch.scrolled      = out_scr_ff;

   // Sequencer: next state, cursor, memory port and response register.
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      attr_in      = (csr_ch.valid) ? csr_ch.data : attr_ff;
      ptr_in       = ptr_ff;
      iss_in       = iss_ff;
      rd_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      puts_in      = puts_ff;
      char_in      = char_ff;
      scr_in       = scr_ff;
      cmd_pop      = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = ptr_ff;
      mem_wdata    = {attr_ff, CHAR_SPACE};
      mem_re       = 1'b0;
      mem_raddr    = ptr_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      out_lin_in   = out_lin_ff;
      out_char_in  = out_char_ff;
      out_attr_in  = out_attr_ff;
      out_scr_in   = out_scr_ff;

      case (state_ff)
         // Blank the whole store once after reset.
         ST_INIT_CLEAR: begin
            mem_we    = 1'b1;
            mem_wdata = {ATTR_RESET, CHAR_SPACE};
            if (ptr_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Take the next command when the response register can be refilled.
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop  = 1'b1;
               scr_in   = 1'b0;
               state_in = ST_DONE;
               case (cmd.kind)
                  CMD_READ: begin
                     if (cmd.in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = read_addr;
                        state_in  = ST_READ_WAIT;
                     end
                  end
                  CMD_PUT: begin
                     puts_in  = PW'(1);
                     char_in  = cmd.char_byte;
                     state_in = ST_PUT;
                  end
                  CMD_TAB: begin
                     puts_in  = PW'(TAB_WIDTH);
                     char_in  = CHAR_SPACE;
                     state_in = ST_PUT;
                  end
                  CMD_NEWLINE: begin
                     col_in  = '0;
                     puts_in = '0;
                     if (row_ff == ROW_LAST) begin
                        scr_in = 1'b1;
                        iss_in = 1'b1;
                        if (HAS_COPY) begin
                           ptr_in   = COPY_SRC0;
                           state_in = ST_SCROLL_COPY;
                        end else begin
                           ptr_in   = BOT_ROW0;
                           state_in = ST_SCROLL_BLANK;
                        end
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  CMD_CR: begin
                     col_in = '0;
                  end
                  CMD_BS: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                  end
                  CMD_FF: begin
                     ptr_in   = '0;
                     state_in = ST_CLEAR;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Read data is registered; send it with the cursor.
         ST_READ_WAIT: begin
            out_valid_in = 1'b1;
            out_col_in   = COL_W'(col_ff);
            out_row_in   = ROW_W'(row_ff);
            out_lin_in   = LINEAR_W'(cur_addr);
            out_char_in  = rd_data_ff[7:0];
            out_attr_in  = rd_data_ff[15:8];
            out_scr_in   = 1'b0;
            state_in     = ST_IDLE;
         end

         // Store one character and advance, wrapping or scrolling as needed.
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {attr_ff, char_ff};
            puts_in   = puts_left;
            state_in  = (puts_left == '0) ? ST_DONE : ST_PUT;
            if (col_ff == COL_LAST) begin
               col_in = '0;
               if (row_ff == ROW_LAST) begin
                  scr_in = 1'b1;
                  iss_in = 1'b1;
                  if (HAS_COPY) begin
                     ptr_in   = COPY_SRC0;
                     state_in = ST_SCROLL_COPY;
                  end else begin
                     ptr_in   = BOT_ROW0;
                     state_in = ST_SCROLL_BLANK;
                  end
               end else begin
                  row_in = row_ff + 1'b1;
               end
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         // Move each cell up one row: read the source, write it in the next cycle.
         ST_SCROLL_COPY: begin
            if (iss_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = ptr_ff;
               rd_pend_in = 1'b1;
               wr_addr_in = ptr_ff - ROW_STEP;
               if (ptr_ff == CELL_LAST) begin
                  iss_in = 1'b0;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
            if (rd_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = wr_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (!iss_ff && !rd_pend_ff) begin
               ptr_in   = BOT_ROW0;
               state_in = ST_SCROLL_BLANK;
            end
         end

         // Fill the bottom row with blanks, then resume the pending puts.
         ST_SCROLL_BLANK: begin
            mem_we = 1'b1;
            iss_in = 1'b0;
            if (ptr_ff == CELL_LAST) begin
               state_in = (puts_ff == '0) ? ST_DONE : ST_PUT;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Form feed: blank every cell and home the cursor.
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (ptr_ff == CELL_LAST) begin
               col_in   = '0;
               row_in   = ROW_HOME;
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end

         // Report the cursor after every command but an in-range read.
         ST_DONE: begin
            out_valid_in = 1'b1;
            out_col_in   = COL_W'(col_ff);
            out_row_in   = ROW_W'(row_ff);
            out_lin_in   = LINEAR_W'(cur_addr);
            out_char_in  = '0;
            out_attr_in  = '0;
            out_scr_in   = scr_ff;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT_CLEAR;
         col_ff       <= '0;
         row_ff       <= ROW_HOME;
         attr_ff      <= ATTR_RESET;
         ptr_ff       <= '0;
         iss_ff       <= 1'b0;
         rd_pend_ff   <= 1'b0;
         puts_ff      <= '0;
         scr_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         attr_ff      <= attr_in;
         ptr_ff       <= ptr_in;
         iss_ff       <= iss_in;
         rd_pend_ff   <= rd_pend_in;
         puts_ff      <= puts_in;
         scr_ff       <= scr_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      char_ff     <= char_in;
      out_col_ff  <= out_col_in;
      out_row_ff  <= out_row_in;
      out_lin_ff  <= out_lin_in;
      out_char_ff <= out_char_in;
      out_attr_ff <= out_attr_in;
      out_scr_ff  <= out_scr_in;
   end

   // Screen store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      32'(row_ff) < ROWS)
      else $error("cursor row beyond the last row");
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      32'(col_ff) < COLUMNS)
      else $error("cursor column beyond the last column");
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT_CLEAR |-> !cmd_pop)
      else $error("command taken during the reset clearing pass");
   a_out_free_on_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE || state_ff == ST_READ_WAIT) |-> !out_valid_ff)
      else $error("response register overwritten before its transfer");

endmodule

### rtl/text_console_char_writer_core.sv
`timescale 1ns / 1ps
// A carriage return, backspace, NUL, bell or out-of-range read answers from the DONE
// state, an in-range read from READ_WAIT after the registered store read; a printable
// put passes through PUT and DONE. A scroll adds the copy and blank loops; a form feed
// adds a pass over every cell. A tab runs four puts. The back end takes the next
// command only after the current one has answered; the queue holds commands meanwhile.
// After reset the store is blanked before the first item.
// Depends on tcw_pkg, tcw_if, tcw_front, tcw_fifo and tcw_back.
module text_console_char_writer_core #(
   parameter int unsigned COLUMNS       = 80,
   parameter int unsigned ROWS          = 25,
   parameter int unsigned RESERVED_ROWS = 2
) (
   input  logic        clock,
   input  logic        reset,
   tcw_req_if.sink     req_ch,
   tcw_rsp_if.source   rsp_ch,
   tcw_csr_if.sink     csr_ch
);
   import tcw_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    push;
   logic    pop;
   logic    not_empty;
   logic    full;

   // Classify request transfers.
   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_ch     (req_ch),
      .queue_full (full),
      .push       (push),
      .cmd        (push_cmd)
   );

   // Decouple the front from the back.
   tcw_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head_cmd  (head_cmd),
      .not_empty (not_empty),
      .full      (full)
   );

   // Execute commands against the screen store.
   tcw_back #(
      .COLUMNS       (COLUMNS),
      .ROWS          (ROWS),
      .RESERVED_ROWS (RESERVED_ROWS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head_cmd),
      .cmd_valid (not_empty),
      .cmd_pop   (pop),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch)
   );

endmodule
